@@ src/rco_pkg.sv @@
// Shared types and fixed port widths for the rod cutting optimizer.
`default_nettype none

package rco_pkg;

    // Widths of the payload fields at the block boundary.
    localparam int IN_PRICE_W = 16;
    localparam int OUT_REV_W  = 22;
    localparam int OUT_LEN_W  = 7;

    // Control that travels with one candidate from the sequencer to the accumulator.
    typedef struct packed {
        logic vld;       // read data for one candidate arrives this cycle
        logic first;     // candidate with a first piece of length one
        logic base_row;  // first piece is the whole rod, remainder revenue is zero
    } t_acc_ctl;

endpackage

`default_nettype wire

@@ src/rco_ram.sv @@
// Simple dual port synchronous memory with a registered read.
`default_nettype none

module rco_ram #(
    parameter int W  = 8,
    parameter int D  = 64,
    parameter int AW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/rco_acc.sv @@
// Add-compare unit that keeps the running best revenue and first cut of one row.
`default_nettype none

module rco_acc #(
    parameter int PRICE_BITS = 16,
    parameter int REV_W      = 22,
    parameter int LEN_W      = 7
) (
    input  wire logic              i_clk,
    input  wire rco_pkg::t_acc_ctl i_ctl,
    input  wire logic [LEN_W-1:0]  i_j,
    input  wire logic [PRICE_BITS-1:0] i_price,
    input  wire logic [REV_W-1:0]  i_rev,
    output logic      [REV_W-1:0]  o_best,
    output logic      [LEN_W-1:0]  o_cut
);

    logic [REV_W-1:0] r_best;
    logic [LEN_W-1:0] r_cut;
    logic [REV_W-1:0] n_best;
    logic [LEN_W-1:0] n_cut;
    logic [REV_W-1:0] cand;
    logic             take;

    // The comparison is strict so that a tie keeps the shorter first piece.
    always_comb begin
        cand   = REV_W'(i_price) + (i_ctl.base_row ? REV_W'(0) : i_rev);
        take   = i_ctl.first || (cand > r_best);
        n_best = take ? cand : r_best;
        n_cut  = take ? i_j : r_cut;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_best <= n_best;
            r_cut  <= n_cut;
        end
    end

    assign o_best = n_best;
    assign o_cut  = n_cut;

endmodule

`default_nettype wire

@@ src/rod_cutting_optimizer_unit.sv @@
// Top level of the rod cutting optimizer: sequencer, memories and output stage.
`default_nettype none

// The block reads a price list one beat at a time, price of length 1 first, and
// the beat that carries i_last_price closes the list; its position is the rod
// length n (prices past MAX_LEN are dropped and n stays at MAX_LEN). While it
// loads, the block takes every price beat offered. After the closing beat the
// input stalls while the block fills the best-revenue and first-cut tables
// bottom up. Row i issues its i candidates for add-compare, one candidate per
// cycle through the single read port of each memory, then writes the row back.
// The write-back step also keeps the next row's first read from overtaking the
// entry just written. The block then walks the first-cut table from the full
// rod downward and presents one output beat per piece; for each piece it reads
// the table, forms the beat and holds it while the output is stalled. Each beat
// carries the total revenue, the piece length and a flag on the final piece.
// Once the final piece is taken the block accepts the next rod's prices. On a
// tie the shorter first piece wins. Memory contents need no clearing after reset.

module rod_cutting_optimizer_unit #(
    parameter int MAX_LEN    = 64,
    parameter int PRICE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Price beats.
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [rco_pkg::IN_PRICE_W-1:0]  i_price_value,
    input  wire logic                            i_last_price,
    // Piece beats.
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [rco_pkg::OUT_REV_W-1:0]   o_total_revenue,
    output logic      [rco_pkg::OUT_LEN_W-1:0]   o_piece_length,
    output logic                                 o_last_piece
);

    localparam int IN_W   = rco_pkg::IN_PRICE_W;
    localparam int OREV_W = rco_pkg::OUT_REV_W;
    localparam int OLEN_W = rco_pkg::OUT_LEN_W;
    // Lengths run 0..MAX_LEN, memory addresses 0..MAX_LEN-1.
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // The revenue of a rod is at most MAX_LEN times the largest price.
    localparam int REV_W  = PRICE_BITS + $clog2(MAX_LEN);
    localparam int ENT_W  = LEN_W + REV_W;

    typedef enum logic [2:0] {
        S_LOAD,   // take price beats
        S_ISSUE,  // read one candidate of the current row per cycle
        S_DRAIN,  // last candidate arrives, row written back
        S_WREQ,   // read the first cut of the remaining rod
        S_WCHK,   // form one piece beat
        S_OUT     // hold the piece beat until it is taken
    } t_state;

    t_state               r_state;
    logic [LEN_W-1:0]     r_cnt;    // loaded prices, then the rod length
    logic [LEN_W-1:0]     r_i;      // row being filled
    logic [LEN_W-1:0]     r_j;      // candidate first piece being issued
    logic [LEN_W-1:0]     r_jd;     // first piece of the candidate in the data stage
    rco_pkg::t_acc_ctl    r_ctl;
    logic [LEN_W-1:0]     r_rem;    // length of rod not yet cut during the walk
    logic [REV_W-1:0]     r_total;
    logic                 r_out_valid;
    logic [OREV_W-1:0]    r_out_rev;
    logic [OLEN_W-1:0]    r_out_len;
    logic                 r_out_last;

    logic                     in_acc;
    logic                     out_acc;
    logic                     cnt_room;
    logic [LEN_W-1:0]         n_cnt;
    logic [IN_W+PRICE_BITS-1:0] price_ext;
    logic [PRICE_BITS-1:0]    price_rd;
    logic [IDX_W-1:0]         price_ra;
    logic [LEN_W-1:0]         j_m1;
    logic [LEN_W-1:0]         rev_ra_full;
    logic [IDX_W-1:0]         rev_ra;
    logic [LEN_W-1:0]         i_m1;
    logic                     tab_we;
    logic [ENT_W-1:0]         tab_wdata;
    logic [ENT_W-1:0]         tab_rd;
    logic [REV_W-1:0]         acc_best;
    logic [LEN_W-1:0]         acc_cut;
    logic [LEN_W-1:0]         rd_cut;
    logic [LEN_W-1:0]         piece;
    logic [LEN_W-1:0]         rem_next;
    logic [OREV_W+REV_W-1:0]  rev_ext;
    logic [OLEN_W+LEN_W-1:0]  len_ext;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;

    // Price beats past MAX_LEN are dropped, the count saturates.
    assign cnt_room  = r_cnt < LEN_W'(MAX_LEN);
    assign n_cnt     = cnt_room ? (r_cnt + LEN_W'(1)) : r_cnt;
    assign price_ext = {PRICE_BITS'(0), i_price_value};

    // Candidate j of row i uses price[j-1] and the revenue of a rod of length i-j.
    assign j_m1        = r_j - LEN_W'(1);
    assign price_ra    = j_m1[IDX_W-1:0];
    assign rev_ra_full = (r_state == S_ISSUE) ? (r_i - r_j - LEN_W'(1))
                                              : (r_rem - LEN_W'(1));
    assign rev_ra      = rev_ra_full[IDX_W-1:0];
    assign i_m1        = r_i - LEN_W'(1);

    rco_ram #(
        .W  (PRICE_BITS),
        .D  (MAX_LEN),
        .AW (IDX_W)
    ) u_price_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && cnt_room),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (price_ext[PRICE_BITS-1:0]),
        .i_raddr (price_ra),
        .o_rdata (price_rd)
    );

    // Each table entry holds the first cut above the best revenue.
    assign tab_we    = (r_state == S_DRAIN);
    assign tab_wdata = {acc_cut, acc_best};

    rco_ram #(
        .W  (ENT_W),
        .D  (MAX_LEN),
        .AW (IDX_W)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (i_m1[IDX_W-1:0]),
        .i_wdata (tab_wdata),
        .i_raddr (rev_ra),
        .o_rdata (tab_rd)
    );

    rco_acc #(
        .PRICE_BITS (PRICE_BITS),
        .REV_W      (REV_W),
        .LEN_W      (LEN_W)
    ) u_acc (
        .i_clk   (i_clk),
        .i_ctl   (r_ctl),
        .i_j     (r_jd),
        .i_price (price_rd),
        .i_rev   (tab_rd[REV_W-1:0]),
        .o_best  (acc_best),
        .o_cut   (acc_cut)
    );

    // Walk back: a stored cut of zero or longer than the rest takes the whole rest.
    assign rd_cut   = tab_rd[ENT_W-1:REV_W];
    assign piece    = ((rd_cut == LEN_W'(0)) || (rd_cut > r_rem)) ? r_rem : rd_cut;
    assign rem_next = r_rem - piece;
    assign rev_ext  = {OREV_W'(0), r_total};
    assign len_ext  = {OLEN_W'(0), piece};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ctl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Read data of a candidate arrives in the cycle after its issue.
            r_ctl.vld <= (r_state == S_ISSUE);
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_cnt <= n_cnt;
                        if (i_last_price) begin
                            r_i     <= LEN_W'(1);
                            r_j     <= LEN_W'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_ctl.first    <= (r_j == LEN_W'(1));
                    r_ctl.base_row <= (r_j == r_i);
                    r_jd           <= r_j;
                    r_j            <= r_j + LEN_W'(1);
                    if (r_j == r_i) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_i == r_cnt) begin
                        r_total <= acc_best;
                        r_rem   <= r_cnt;
                        r_state <= S_WREQ;
                    end else begin
                        r_i     <= r_i + LEN_W'(1);
                        r_j     <= LEN_W'(1);
                        r_state <= S_ISSUE;
                    end
                end
                S_WREQ: begin
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    r_out_valid <= 1'b1;
                    r_out_rev   <= rev_ext[OREV_W-1:0];
                    r_out_len   <= len_ext[OLEN_W-1:0];
                    r_out_last  <= (rem_next == LEN_W'(0));
                    r_rem       <= rem_next;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_WREQ;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != S_LOAD);
    assign o_valid         = r_out_valid;
    assign o_total_revenue = r_out_rev;
    assign o_piece_length  = r_out_len;
    assign o_last_piece    = r_out_last;

    // The loaded count never passes the table depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LEN_W'(MAX_LEN))
        else $error("loaded count exceeds table depth");

    // A row is only written back when its last candidate is in the data stage.
    a_drain_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_ctl.vld && r_ctl.base_row && (r_jd == r_i)))
        else $error("row written back without its final candidate");

    // Every piece beat carries a length between one and the rod length.
    a_piece_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_piece_length != OLEN_W'(0))
                     && (o_piece_length <= OLEN_W'(r_cnt))))
        else $error("piece length out of range");

    // Taking the final piece reopens the input for a fresh rod.
    a_rod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_piece) |=> (!o_stall && (r_cnt == LEN_W'(0))))
        else $error("block did not return to loading after the final piece");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the rod cutting optimizer: price rods in, checked piece beats out.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_PRICE_W = rco_pkg::IN_PRICE_W;
    localparam int OUT_REV_W  = rco_pkg::OUT_REV_W;
    localparam int OUT_LEN_W  = rco_pkg::OUT_LEN_W;

    // Rod length limit of the block as instantiated, and the run's cycle budget.
    localparam int ROD_MAX     = 64;
    localparam int CYCLE_LIMIT = 400000;
    // Random price beats to send after the directed table.
    localparam int RANDOM_ITEMS = 200;

    // One piece of an optimal cut as it appears on the output side.
    typedef struct packed {
        logic [OUT_REV_W-1:0] rev;
        logic [OUT_LEN_W-1:0] len;
        logic                 fin;
    } t_piece;

    // One row of the directed table. Rows marked hand_checked carry a typed-in
    // single piece; every other row is checked against the cut planner below.
    typedef struct packed {
        logic [IN_PRICE_W-1:0] price;
        logic                  last;
        bit                    hand_checked;
        logic [OUT_REV_W-1:0]  want_rev;
        logic [OUT_LEN_W-1:0]  want_len;
    } t_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic [IN_PRICE_W-1:0] i_price_value = '0;
    logic                  i_last_price  = 1'b0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [OUT_REV_W-1:0]  o_total_revenue;
    logic [OUT_LEN_W-1:0]  o_piece_length;
    logic                  o_last_piece;

    // Cut planner state: prices of the rod being loaded and the two tables that
    // the bottom-up fill produces.
    logic [IN_PRICE_W-1:0] price_mem [ROD_MAX];
    int unsigned           rev_mem   [ROD_MAX];
    int unsigned           cut_mem   [ROD_MAX];
    int unsigned           prices_held = 0;

    // Pieces still owed by the block, oldest first.
    t_piece pieces_due [$];
    t_row   table_rows [$];
    t_piece piece_want;

    int unsigned errors       = 0;
    int unsigned beats_sent   = 0;
    int unsigned pieces_taken = 0;
    int unsigned rods_closed  = 0;
    int unsigned long_rods    = 0;
    int unsigned cycle_count  = 0;

    rod_cutting_optimizer_unit #(
        .MAX_LEN    (ROD_MAX),
        .PRICE_BITS (16)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_price_value   (i_price_value),
        .i_last_price    (i_last_price),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_total_revenue (o_total_revenue),
        .o_piece_length  (o_piece_length),
        .o_last_piece    (o_last_piece)
    );

    always #10 i_clk = ~i_clk;

    // Cycle budget; a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pieces still owed", $realtime, pieces_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // Takes one accepted price beat. A non-final price is only stored (prices past
    // the limit are dropped). A final price fills the best-revenue and first-cut
    // tables bottom up, with the strict compare that keeps the shortest first piece
    // on a tie, then walks back from the full rod and queues one piece per cut.
    // With queue_pieces clear the state moves on but nothing is queued.
    task automatic plan_cuts(input logic [IN_PRICE_W-1:0] price, input logic last,
                             input bit queue_pieces);
        int unsigned rod_len, i, j, rem, cand, top, cut;
        t_piece      pc;
        if (prices_held < ROD_MAX) begin
            price_mem[prices_held] = price;
            prices_held++;
        end
        if (last) begin
            rod_len = prices_held;
            for (i = 1; i <= rod_len; i++) begin
                top = 0;
                cut = 1;
                for (j = 1; j <= i; j++) begin
                    cand = price_mem[j-1] + ((j == i) ? 0 : rev_mem[i-j-1]);
                    if (j == 1 || cand > top) begin
                        top = cand;
                        cut = j;
                    end
                end
                rev_mem[i-1] = top;
                cut_mem[i-1] = cut;
            end
            rem = rod_len;
            while (rem > 0) begin
                pc.len = OUT_LEN_W'(cut_mem[rem-1]);
                rem    = rem - cut_mem[rem-1];
                pc.rev = OUT_REV_W'(rev_mem[rod_len-1]);
                pc.fin = (rem == 0);
                if (queue_pieces)
                    pieces_due = {pieces_due, pc};
            end
            prices_held = 0;
            rods_closed++;
        end
    endtask

    // Offers one price beat after a random gap and waits until the block takes it.
    // Valid is lowered only when a gap follows, so it never toggles within a step.
    task automatic offer_price(input logic [IN_PRICE_W-1:0] price, input logic last,
                               input bit hand_checked, input logic [OUT_REV_W-1:0] want_rev,
                               input logic [OUT_LEN_W-1:0] want_len);
        int unsigned gap;
        t_piece      pc;
        // Every 64 beats the first ten go back to back.
        gap = ((beats_sent % 64) < 10) ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_price_value <= price;
        i_last_price  <= last;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        // The beat was taken at this edge.
        plan_cuts(price, last, !hand_checked);
        if (hand_checked) begin
            pc.rev = want_rev;
            pc.len = want_len;
            pc.fin = 1'b1;
            pieces_due = {pieces_due, pc};
        end
        beats_sent++;
    endtask

    function automatic t_row mk_row(input logic [IN_PRICE_W-1:0] price, input logic last,
                                    input bit hand_checked, input int unsigned want_rev,
                                    input int unsigned want_len);
        t_row r;
        r.price        = price;
        r.last         = last;
        r.hand_checked = hand_checked;
        r.want_rev     = OUT_REV_W'(want_rev);
        r.want_len     = OUT_LEN_W'(want_len);
        return r;
    endfunction

    // Price shapes: full random, tiny values that tie often, near-linear prices
    // where many cuts are equally good, a mix of the two extremes, and the top
    // price throughout.
    function automatic logic [IN_PRICE_W-1:0] pick_price(input int unsigned shape,
                                                         input int unsigned pos,
                                                         input int unsigned slope);
        int unsigned v;
        case (shape)
            0: v = $urandom_range(0, 65535);
            1: v = $urandom_range(0, 15);
            2: begin
                v = pos * slope + $urandom_range(0, 1);
                if (v > 65535)
                    v = 65535;
            end
            3: v = $urandom_range(0, 1) ? 65535 : 0;
            default: v = 65535;
        endcase
        return v[IN_PRICE_W-1:0];
    endfunction

    // Sends one rod of rod_len price beats; the flag rides on the last one. Rods
    // longer than the limit put the flag on a price that the block drops.
    task automatic send_rod(input int unsigned rod_len, input int unsigned shape);
        int unsigned k, slope;
        slope = $urandom_range(0, 1000);
        for (k = 1; k <= rod_len; k++)
            offer_price(pick_price(shape, k, slope), k == rod_len, 1'b0, '0, '0);
        if (rod_len >= ROD_MAX)
            long_rods++;
    endtask

    // Output check: every taken piece beat is compared with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            pieces_taken <= pieces_taken + 1;
            if (pieces_due.size() == 0) begin
                errors = errors + 1;
                $display("%0t: piece beat with none expected: revenue %0d length %0d last %0b",
                         $realtime, o_total_revenue, o_piece_length, o_last_piece);
            end else begin
                piece_want = pieces_due.pop_front();
                if (o_total_revenue !== piece_want.rev) begin
                    errors = errors + 1;
                    $display("%0t: total_revenue expected %0d actual %0d",
                             $realtime, piece_want.rev, o_total_revenue);
                end
                if (o_piece_length !== piece_want.len) begin
                    errors = errors + 1;
                    $display("%0t: piece_length expected %0d actual %0d",
                             $realtime, piece_want.len, o_piece_length);
                end
                if (o_last_piece !== piece_want.fin) begin
                    errors = errors + 1;
                    $display("%0t: last_piece expected %0b actual %0b",
                             $realtime, piece_want.fin, o_last_piece);
                end
            end
        end
    end

    // Receiver: stalls a random number of cycles before each beat, with stretches
    // of no stalling. Twice it holds off for a long stretch so that the block
    // backs up and stalls the price side while the sender keeps offering.
    initial begin
        int unsigned pause, got, holds;
        got   = 0;
        holds = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ((got >= 12 && holds == 0) || (got >= 150 && holds == 1)) begin
                pause = 600;
                holds++;
            end else begin
                pause = ((got % 50) < 8) ? 0 : $urandom_range(0, 12);
            end
            if (pause != 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            got++;
        end
    end

    // Main sequence: reset, directed table, forced long rods, then random rods.
    initial begin
        int unsigned idx, random_beats, r, rod_len;
        t_row        row;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-price rods at both price extremes.
        table_rows = {table_rows, mk_row(16'h0000, 1'b1, 1'b1, 0, 1)};
        table_rows = {table_rows, mk_row(16'hFFFF, 1'b1, 1'b1, 65535, 1)};
        // Alternating bit patterns; the two cuts tie and the shorter first piece wins.
        table_rows = {table_rows, mk_row(16'h5555, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'hAAAA, 1'b1, 1'b0, 0, 0)};
        // The textbook three-price rod.
        table_rows = {table_rows, mk_row(16'h0001, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0005, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0008, 1'b1, 1'b0, 0, 0)};
        // Exact tie between two halves and the whole rod.
        table_rows = {table_rows, mk_row(16'h0003, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0006, 1'b1, 1'b0, 0, 0)};
        // Only unit pieces earn anything.
        table_rows = {table_rows, mk_row(16'hFFFF, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0000, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0000, 1'b1, 1'b0, 0, 0)};
        // Only the whole rod earns anything: one piece of length two.
        table_rows = {table_rows, mk_row(16'h0000, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'hFFFF, 1'b1, 1'b1, 65535, 2)};
        // Mixed magnitudes around the top bit.
        table_rows = {table_rows, mk_row(16'h0001, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h8000, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h7FFF, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0002, 1'b1, 1'b0, 0, 0)};
        // All-zero prices: revenue zero, every first cut of length one.
        table_rows = {table_rows, mk_row(16'h0000, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0000, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0000, 1'b0, 1'b0, 0, 0)};
        table_rows = {table_rows, mk_row(16'h0000, 1'b1, 1'b0, 0, 0)};

        for (idx = 0; idx < table_rows.size(); idx++) begin
            row = table_rows[idx];
            offer_price(row.price, row.last, row.hand_checked, row.want_rev, row.want_len);
        end

        // Full-length rod at the top price: the largest revenue and 64 unit pieces.
        send_rod(ROD_MAX, 4);
        // Flag on a dropped price, well past the limit and just past it.
        send_rod(ROD_MAX + 6, 0);
        send_rod(ROD_MAX + 1, 2);

        // Random rods, mostly short, a few at or beyond the limit.
        random_beats = 0;
        while (random_beats < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                rod_len = $urandom_range(1, 8);
            else if (r < 90)
                rod_len = $urandom_range(9, 24);
            else if (r < 96)
                rod_len = $urandom_range(25, ROD_MAX);
            else
                rod_len = $urandom_range(ROD_MAX + 1, ROD_MAX + 8);
            send_rod(rod_len, $urandom_range(0, 3));
            random_beats += rod_len;
        end
        i_valid <= 1'b0;

        while (pieces_due.size() != 0) @(posedge i_clk);
        // Keep running so that any stray extra piece beat is caught.
        repeat (40) @(posedge i_clk);

        $display("Sent %0d price beats forming %0d rods (%0d at or past the length limit).",
                 beats_sent, rods_closed, long_rods);
        $display("Checked %0d piece beats, %0d mismatches.", pieces_taken, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/rco_pkg.sv
src/rco_ram.sv
src/rco_acc.sv
src/rod_cutting_optimizer_unit.sv
tb/sv/tb_top.sv
